>>> rtl/core/mcskv_pkg.sv
// ----------------------------------------------------------------------------
// mcskv_pkg
// Shared constants, codes and controller/datapath interface types for the
// multi-context sorted key/value store.
// ----------------------------------------------------------------------------
`default_nettype none

package mcskv_pkg;

    // sizing
    localparam int NUM_ENVS  = 8;
    localparam int ENTRIES   = 16;
    localparam int ENV_W     = 3;    // slot / context index
    localparam int CNT_W     = 4;    // context count, 0 .. NUM_ENVS
    localparam int ENT_W     = 4;    // entry index within a slot
    localparam int N_W       = 5;    // entry count, 0 .. ENTRIES
    localparam int ADDR_W    = ENV_W + ENT_W;
    localparam int MEM_DEPTH = NUM_ENVS * ENTRIES;
    localparam int KEY_W     = 32;
    localparam int VAL_W     = 64;

    // request opcodes
    localparam logic [2:0] OP_GET     = 3'd0;
    localparam logic [2:0] OP_SET     = 3'd1;
    localparam logic [2:0] OP_UNSET   = 3'd2;
    localparam logic [2:0] OP_CREATE  = 3'd3;
    localparam logic [2:0] OP_CLONE   = 3'd4;
    localparam logic [2:0] OP_RELEASE = 3'd5;
    localparam logic [2:0] OP_DUMP    = 3'd6;
    localparam logic [2:0] OP_RSVD    = 3'd7;   // unassigned, answered with zeros

    // result status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_BAD_CTX = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    // datapath micro-operations
    typedef enum logic [4:0] {
        MOP_NONE,
        MOP_LOAD,
        MOP_MAP,
        MOP_CNT,
        MOP_RD_IDX,
        MOP_CMP,
        MOP_ENDS,
        MOP_SET_INIT,
        MOP_RD_PREV,
        MOP_WR_UP,
        MOP_WR_KV,
        MOP_IDX_POS,
        MOP_RD_NEXT,
        MOP_WR_DN,
        MOP_DEC,
        MOP_WR_COPY,
        MOP_NEWCTX,
        MOP_RELEASE,
        MOP_IDX_INC
    } t_mop;

    // result kinds
    typedef enum logic [2:0] {
        EM_ZERO,
        EM_BAD,
        EM_FULL0,
        EM_FULLN,
        EM_OK,
        EM_NEW,
        EM_DUMP
    } t_em;

    typedef struct packed {
        t_mop mop;
        logic emit;
        t_em  em;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       valid_ctx;
        logic       ctx_full;
        logic       tbl_full;
        logic       idx_ge_n;
        logic       lt;
        logic       idx_gt_pos;
        logic       idx1_lt_n;
        logic       match;
        logic       dump_more;
        logic       dump_next;
        logic       out_free;
    } t_status;

endpackage

`default_nettype wire

>>> rtl/core/multi_context_sorted_kv_store.sv
// ----------------------------------------------------------------------------
// multi_context_sorted_kv_store
// Several key-sorted key/value tables with get, set, unset, create, clone,
// release and dump requests, one request at a time.
// ----------------------------------------------------------------------------
// Flow: each request passes through context lookup and count load; get, set
//   and unset then search the keys and set/unset shift entries where needed,
//   clone copies the entries to a new slot and dump returns one pair per result.
// Requests are taken one at a time (tables of up to 16 entries): the next one
//   is taken once the result has been issued, and output stalls delay it.
// Reset (synchronous, active low): one empty context, identity slot map.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_context_sorted_kv_store (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [2:0]                  i_opcode,
    input  wire logic [7:0]                  i_context_id,
    input  wire logic [mcskv_pkg::KEY_W-1:0] i_key,
    input  wire logic [mcskv_pkg::VAL_W-1:0] i_data_value,
    input  wire logic [5:0]                  i_dump_words,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [1:0]                       o_status,
    output logic                             o_found,
    output logic [2:0]                       o_new_context,
    output logic [mcskv_pkg::KEY_W-1:0]      o_out_key,
    output logic [mcskv_pkg::VAL_W-1:0]      o_out_value,
    output logic [5:0]                       o_size_words,
    output logic [5:0]                       o_words_written,
    output logic                             o_last
);

    mcskv_pkg::t_cmd    cmd;
    mcskv_pkg::t_status st;

    // request sequencer
    mcskv_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_st    (st),
        .o_cmd   (cmd)
    );

    // storage and result register
    mcskv_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_st            (st),
        .i_opcode        (i_opcode),
        .i_context_id    (i_context_id),
        .i_key           (i_key),
        .i_data_value    (i_data_value),
        .i_dump_words    (i_dump_words),
        .i_ready         (i_ready),
        .o_valid         (o_valid),
        .o_status        (o_status),
        .o_found         (o_found),
        .o_new_context   (o_new_context),
        .o_out_key       (o_out_key),
        .o_out_value     (o_out_value),
        .o_size_words    (o_size_words),
        .o_words_written (o_words_written),
        .o_last          (o_last)
    );

endmodule

`default_nettype wire

>>> rtl/core/mcskv_ctrl.sv
// ----------------------------------------------------------------------------
// mcskv_ctrl
// Request sequencer: walks each request through lookup, sorted search,
// shift, copy and result phases by issuing micro-operations to the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

module mcskv_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire mcskv_pkg::t_status i_st,
    output mcskv_pkg::t_cmd         o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_MAP, S_CNT, S_DISP, S_SRD, S_SCMP, S_SACT,
        S_SHR, S_SHW, S_WKV, S_DNR, S_DNW, S_DEC,
        S_CPR, S_CPW, S_FIN, S_DRD, S_DEM, S_EMIT
    } t_state;

    t_state         r_state, n_state;
    mcskv_pkg::t_em r_em, n_em;

    assign o_ready = (r_state == S_IDLE);

    // next state and command
    always_comb begin
        n_state    = r_state;
        n_em       = r_em;
        o_cmd.mop  = mcskv_pkg::MOP_NONE;
        o_cmd.emit = 1'b0;
        o_cmd.em   = r_em;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.mop = mcskv_pkg::MOP_LOAD;
                    n_state   = S_MAP;
                end
            end
            S_MAP: begin
                o_cmd.mop = mcskv_pkg::MOP_MAP;
                n_state   = S_CNT;
            end
            S_CNT: begin
                o_cmd.mop = mcskv_pkg::MOP_CNT;
                n_state   = S_DISP;
            end
            S_DISP: begin
                case (i_st.op)
                    mcskv_pkg::OP_CREATE: begin
                        if (i_st.ctx_full) begin
                            n_em    = mcskv_pkg::EM_FULL0;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_FIN;
                        end
                    end
                    mcskv_pkg::OP_GET, mcskv_pkg::OP_SET, mcskv_pkg::OP_UNSET: begin
                        if (!i_st.valid_ctx) begin
                            n_em    = mcskv_pkg::EM_BAD;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_SRD;
                        end
                    end
                    mcskv_pkg::OP_CLONE: begin
                        if (!i_st.valid_ctx) begin
                            n_em    = mcskv_pkg::EM_BAD;
                            n_state = S_EMIT;
                        end else if (i_st.ctx_full) begin
                            n_em    = mcskv_pkg::EM_FULLN;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_CPR;
                        end
                    end
                    mcskv_pkg::OP_RELEASE: begin
                        if (!i_st.valid_ctx) begin
                            n_em = mcskv_pkg::EM_BAD;
                        end else begin
                            o_cmd.mop = mcskv_pkg::MOP_RELEASE;
                            n_em      = mcskv_pkg::EM_OK;
                        end
                        n_state = S_EMIT;
                    end
                    mcskv_pkg::OP_DUMP: begin
                        if (!i_st.valid_ctx) begin
                            n_em    = mcskv_pkg::EM_BAD;
                            n_state = S_EMIT;
                        end else begin
                            n_state = S_DRD;
                        end
                    end
                    default: begin
                        n_em    = mcskv_pkg::EM_ZERO;
                        n_state = S_EMIT;
                    end
                endcase
            end
            // linear search for the first key not below the request key
            S_SRD: begin
                if (i_st.idx_ge_n) begin
                    o_cmd.mop = mcskv_pkg::MOP_ENDS;
                    n_state   = S_SACT;
                end else begin
                    o_cmd.mop = mcskv_pkg::MOP_RD_IDX;
                    n_state   = S_SCMP;
                end
            end
            S_SCMP: begin
                o_cmd.mop = mcskv_pkg::MOP_CMP;
                n_state   = i_st.lt ? S_SRD : S_SACT;
            end
            S_SACT: begin
                case (i_st.op)
                    mcskv_pkg::OP_SET: begin
                        if (i_st.match) begin
                            n_state = S_WKV;
                        end else if (i_st.tbl_full) begin
                            n_em    = mcskv_pkg::EM_FULLN;
                            n_state = S_EMIT;
                        end else begin
                            o_cmd.mop = mcskv_pkg::MOP_SET_INIT;
                            n_state   = S_SHR;
                        end
                    end
                    mcskv_pkg::OP_UNSET: begin
                        if (i_st.match) begin
                            o_cmd.mop = mcskv_pkg::MOP_IDX_POS;
                            n_state   = S_DNR;
                        end else begin
                            n_em    = mcskv_pkg::EM_OK;
                            n_state = S_EMIT;
                        end
                    end
                    default: begin
                        n_em    = mcskv_pkg::EM_OK;
                        n_state = S_EMIT;
                    end
                endcase
            end
            // insert: move entries up one place from the top down
            S_SHR: begin
                if (i_st.idx_gt_pos) begin
                    o_cmd.mop = mcskv_pkg::MOP_RD_PREV;
                    n_state   = S_SHW;
                end else begin
                    n_state = S_WKV;
                end
            end
            S_SHW: begin
                o_cmd.mop = mcskv_pkg::MOP_WR_UP;
                n_state   = S_SHR;
            end
            S_WKV: begin
                o_cmd.mop = mcskv_pkg::MOP_WR_KV;
                n_em      = mcskv_pkg::EM_OK;
                n_state   = S_EMIT;
            end
            // delete: move entries down one place
            S_DNR: begin
                if (i_st.idx1_lt_n) begin
                    o_cmd.mop = mcskv_pkg::MOP_RD_NEXT;
                    n_state   = S_DNW;
                end else begin
                    n_state = S_DEC;
                end
            end
            S_DNW: begin
                o_cmd.mop = mcskv_pkg::MOP_WR_DN;
                n_state   = S_DNR;
            end
            S_DEC: begin
                o_cmd.mop = mcskv_pkg::MOP_DEC;
                n_em      = mcskv_pkg::EM_OK;
                n_state   = S_EMIT;
            end
            // clone copy walk
            S_CPR: begin
                if (!i_st.idx_ge_n) begin
                    o_cmd.mop = mcskv_pkg::MOP_RD_IDX;
                    n_state   = S_CPW;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_CPW: begin
                o_cmd.mop = mcskv_pkg::MOP_WR_COPY;
                n_state   = S_CPR;
            end
            S_FIN: begin
                if (i_st.out_free) begin
                    o_cmd.mop  = mcskv_pkg::MOP_NEWCTX;
                    o_cmd.emit = 1'b1;
                    o_cmd.em   = mcskv_pkg::EM_NEW;
                    n_state    = S_IDLE;
                end
            end
            // dump walk, one pair per transaction
            S_DRD: begin
                if (i_st.dump_more) begin
                    o_cmd.mop = mcskv_pkg::MOP_RD_IDX;
                    n_state   = S_DEM;
                end else begin
                    n_em    = mcskv_pkg::EM_OK;
                    n_state = S_EMIT;
                end
            end
            S_DEM: begin
                if (i_st.out_free) begin
                    o_cmd.mop  = mcskv_pkg::MOP_IDX_INC;
                    o_cmd.emit = 1'b1;
                    o_cmd.em   = mcskv_pkg::EM_DUMP;
                    n_state    = i_st.dump_next ? S_DRD : S_IDLE;
                end
            end
            S_EMIT: begin
                if (i_st.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_em    <= mcskv_pkg::EM_ZERO;
        end else begin
            r_state <= n_state;
            r_em    <= n_em;
        end
    end

`ifndef SYNTH
    // a result is never issued from idle
    a_emit_not_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (r_state != S_IDLE))
        else $error("result issued from idle");

    // a load always starts the context lookup
    a_load_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.mop == mcskv_pkg::MOP_LOAD) |=> (r_state == S_MAP))
        else $error("load not followed by lookup");

    // every emission waits for room in the result register
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_st.out_free)
        else $error("result issued while output busy");
`endif

endmodule

`default_nettype wire

>>> rtl/core/mcskv_dp.sv
// ----------------------------------------------------------------------------
// mcskv_dp
// Datapath: context map, entry counts, pair memory, request registers and
// the result register. Carries out one micro-operation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mcskv_dp (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire mcskv_pkg::t_cmd                   i_cmd,
    output mcskv_pkg::t_status                     o_st,
    input  wire logic [2:0]                        i_opcode,
    input  wire logic [7:0]                        i_context_id,
    input  wire logic [mcskv_pkg::KEY_W-1:0]       i_key,
    input  wire logic [mcskv_pkg::VAL_W-1:0]       i_data_value,
    input  wire logic [5:0]                        i_dump_words,
    input  wire logic                              i_ready,
    output logic                                   o_valid,
    output logic [1:0]                             o_status,
    output logic                                   o_found,
    output logic [2:0]                             o_new_context,
    output logic [mcskv_pkg::KEY_W-1:0]            o_out_key,
    output logic [mcskv_pkg::VAL_W-1:0]            o_out_value,
    output logic [5:0]                             o_size_words,
    output logic [5:0]                             o_words_written,
    output logic                                   o_last
);

    localparam int PAIR_W = mcskv_pkg::KEY_W + mcskv_pkg::VAL_W;

    // context state
    logic [mcskv_pkg::CNT_W-1:0] r_count;
    logic [mcskv_pkg::ENV_W-1:0] r_map [mcskv_pkg::NUM_ENVS];
    logic [mcskv_pkg::N_W-1:0]   r_ecnt [mcskv_pkg::NUM_ENVS];

    // pair memory
    logic [PAIR_W-1:0] r_mem [mcskv_pkg::MEM_DEPTH];
    logic [PAIR_W-1:0] r_rdata;

    // request registers
    logic [2:0]                  r_op;
    logic [7:0]                  r_ctx;
    logic [mcskv_pkg::KEY_W-1:0] r_key;
    logic [mcskv_pkg::VAL_W-1:0] r_val;
    logic [5:0]                  r_len;
    logic [mcskv_pkg::ENV_W-1:0] r_slot;
    logic [mcskv_pkg::ENV_W-1:0] r_ns;
    logic                        r_valid;
    logic [mcskv_pkg::N_W-1:0]   r_n;
    logic [mcskv_pkg::N_W-1:0]   r_idx;
    logic [mcskv_pkg::N_W-1:0]   r_pos;
    logic                        r_match;
    logic [mcskv_pkg::VAL_W-1:0] r_hitval;

    // result register
    logic                        r_ovalid;
    logic [1:0]                  r_ostatus;
    logic                        r_ofound;
    logic [2:0]                  r_onew;
    logic [mcskv_pkg::KEY_W-1:0] r_okey;
    logic [mcskv_pkg::VAL_W-1:0] r_oval;
    logic [5:0]                  r_osize;
    logic [5:0]                  r_oww;
    logic                        r_olast;

    logic [mcskv_pkg::KEY_W-1:0] rd_key;
    logic [mcskv_pkg::VAL_W-1:0] rd_val;
    logic [mcskv_pkg::N_W-1:0]   idx_inc;
    logic [mcskv_pkg::N_W-1:0]   idx_dec;
    logic [mcskv_pkg::ENV_W-1:0] top_ctx;
    logic [5:0]                  size_w;
    logic                        out_free;
    logic                        get_hit;
    logic                        mem_we;
    logic [mcskv_pkg::ADDR_W-1:0] wr_addr;
    logic [mcskv_pkg::ADDR_W-1:0] rd_addr;
    logic [PAIR_W-1:0]           wr_data;

    function automatic logic [mcskv_pkg::CNT_W-1:0] CNT_W_EXT(input int v);
        return mcskv_pkg::CNT_W'(v);
    endfunction

    assign rd_key   = r_rdata[PAIR_W-1:mcskv_pkg::VAL_W];
    assign rd_val   = r_rdata[mcskv_pkg::VAL_W-1:0];
    assign idx_inc  = r_idx + 1'b1;
    assign idx_dec  = r_idx - 1'b1;
    assign top_ctx  = mcskv_pkg::ENV_W'(r_count - 1'b1);
    assign size_w   = {r_n, 1'b0};
    assign out_free = !r_ovalid || i_ready;
    assign get_hit  = r_match && (r_op == mcskv_pkg::OP_GET);

    // status to the controller
    always_comb begin
        o_st.op         = r_op;
        o_st.valid_ctx  = r_valid;
        o_st.ctx_full   = (r_count >= mcskv_pkg::CNT_W'(mcskv_pkg::NUM_ENVS));
        o_st.tbl_full   = (r_n >= mcskv_pkg::N_W'(mcskv_pkg::ENTRIES));
        o_st.idx_ge_n   = (r_idx >= r_n);
        o_st.lt         = (rd_key < r_key);
        o_st.idx_gt_pos = (r_idx > r_pos);
        o_st.idx1_lt_n  = (idx_inc < r_n);
        o_st.match      = r_match;
        o_st.dump_more  = (r_idx < r_n) && ({r_idx, 1'b1} < r_len);
        o_st.dump_next  = (idx_inc < r_n) && ({idx_inc, 1'b1} < r_len);
        o_st.out_free   = out_free;
    end

    // memory address and data selection
    always_comb begin
        mem_we  = 1'b0;
        wr_addr = {r_slot, r_idx[mcskv_pkg::ENT_W-1:0]};
        wr_data = r_rdata;
        rd_addr = {r_slot, r_idx[mcskv_pkg::ENT_W-1:0]};
        case (i_cmd.mop)
            mcskv_pkg::MOP_RD_PREV: rd_addr = {r_slot, idx_dec[mcskv_pkg::ENT_W-1:0]};
            mcskv_pkg::MOP_RD_NEXT: rd_addr = {r_slot, idx_inc[mcskv_pkg::ENT_W-1:0]};
            mcskv_pkg::MOP_WR_UP,
            mcskv_pkg::MOP_WR_DN: mem_we = 1'b1;
            mcskv_pkg::MOP_WR_KV: begin
                mem_we  = 1'b1;
                wr_addr = {r_slot, r_pos[mcskv_pkg::ENT_W-1:0]};
                wr_data = {r_key, r_val};
            end
            mcskv_pkg::MOP_WR_COPY: begin
                mem_we  = 1'b1;
                wr_addr = {r_ns, r_idx[mcskv_pkg::ENT_W-1:0]};
            end
            default: mem_we = 1'b0;
        endcase
    end

    // pair memory, one write and one registered read
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rdata <= r_mem[rd_addr];
    end

    // context map and counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= mcskv_pkg::CNT_W'(1);
            for (int i = 0; i < mcskv_pkg::NUM_ENVS; i++) begin
                r_map[i]  <= mcskv_pkg::ENV_W'(i);
                r_ecnt[i] <= '0;
            end
        end else begin
            case (i_cmd.mop)
                mcskv_pkg::MOP_WR_KV: begin
                    if (!r_match) begin
                        r_ecnt[r_slot] <= r_n + 1'b1;
                    end
                end
                mcskv_pkg::MOP_DEC: r_ecnt[r_slot] <= r_n - 1'b1;
                mcskv_pkg::MOP_NEWCTX: begin
                    r_ecnt[r_ns] <= (r_op == mcskv_pkg::OP_CLONE) ? r_n : '0;
                    r_count      <= r_count + 1'b1;
                end
                mcskv_pkg::MOP_RELEASE: begin
                    for (int i = 0; i < mcskv_pkg::NUM_ENVS - 1; i++) begin
                        if ((8'(i) >= r_ctx) && (CNT_W_EXT(i + 1) < r_count)) begin
                            r_map[i] <= r_map[i+1];
                        end
                    end
                    r_map[top_ctx] <= r_slot;
                    r_count        <= r_count - 1'b1;
                end
                default: r_count <= r_count;
            endcase
        end
    end

    // request registers and walk indices
    always_ff @(posedge i_clk) begin
        case (i_cmd.mop)
            mcskv_pkg::MOP_LOAD: begin
                r_op    <= i_opcode;
                r_ctx   <= i_context_id;
                r_key   <= i_key;
                r_val   <= i_data_value;
                r_len   <= i_dump_words;
                r_idx   <= '0;
                r_match <= 1'b0;
            end
            mcskv_pkg::MOP_MAP: begin
                r_slot  <= r_map[r_ctx[mcskv_pkg::ENV_W-1:0]];
                r_valid <= (r_ctx < {4'd0, r_count});
            end
            mcskv_pkg::MOP_CNT: begin
                r_n  <= r_valid ? r_ecnt[r_slot] : '0;
                r_ns <= r_map[r_count[mcskv_pkg::ENV_W-1:0]];
            end
            mcskv_pkg::MOP_CMP: begin
                if (rd_key < r_key) begin
                    r_idx <= idx_inc;
                end else begin
                    r_pos    <= r_idx;
                    r_match  <= (rd_key == r_key);
                    r_hitval <= rd_val;
                end
            end
            mcskv_pkg::MOP_ENDS:     r_pos <= r_idx;
            mcskv_pkg::MOP_SET_INIT: r_idx <= r_n;
            mcskv_pkg::MOP_WR_UP:    r_idx <= idx_dec;
            mcskv_pkg::MOP_WR_KV: begin
                if (!r_match) begin
                    r_n <= r_n + 1'b1;
                end
            end
            mcskv_pkg::MOP_IDX_POS:  r_idx <= r_pos;
            mcskv_pkg::MOP_WR_DN,
            mcskv_pkg::MOP_WR_COPY,
            mcskv_pkg::MOP_IDX_INC:  r_idx <= idx_inc;
            mcskv_pkg::MOP_DEC:      r_n   <= r_n - 1'b1;
            default:                 r_idx <= r_idx;
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_ostatus <= mcskv_pkg::ST_OK;
            r_ofound  <= 1'b0;
            r_onew    <= '0;
            r_okey    <= '0;
            r_oval    <= '0;
            r_osize   <= '0;
            r_oww     <= '0;
            r_olast   <= 1'b1;
            case (i_cmd.em)
                mcskv_pkg::EM_BAD:   r_ostatus <= mcskv_pkg::ST_BAD_CTX;
                mcskv_pkg::EM_FULL0: r_ostatus <= mcskv_pkg::ST_FULL;
                mcskv_pkg::EM_FULLN: begin
                    r_ostatus <= mcskv_pkg::ST_FULL;
                    r_osize   <= size_w;
                end
                mcskv_pkg::EM_OK: begin
                    r_ofound <= get_hit;
                    r_oval   <= get_hit ? r_hitval : '0;
                    r_osize  <= size_w;
                end
                mcskv_pkg::EM_NEW: begin
                    r_onew  <= r_count[2:0];
                    r_osize <= (r_op == mcskv_pkg::OP_CLONE) ? size_w : '0;
                end
                mcskv_pkg::EM_DUMP: begin
                    r_ofound <= 1'b1;
                    r_okey   <= rd_key;
                    r_oval   <= rd_val;
                    r_osize  <= size_w;
                    r_oww    <= {idx_inc, 1'b0};
                    r_olast  <= !o_st.dump_next;
                end
                default: r_ostatus <= mcskv_pkg::ST_OK;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_ostatus;
    assign o_found         = r_ofound;
    assign o_new_context   = r_onew;
    assign o_out_key       = r_okey;
    assign o_out_value     = r_oval;
    assign o_size_words    = r_osize;
    assign o_words_written = r_oww;
    assign o_last          = r_olast;

`ifndef SYNTH
    // context count stays within the store
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= mcskv_pkg::CNT_W'(mcskv_pkg::NUM_ENVS))
        else $error("context count overflow");

    // release removes exactly one context
    a_release_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mop == mcskv_pkg::MOP_RELEASE) |=> (r_count == $past(r_count) - 1'b1))
        else $error("release count mismatch");

    // a new context is never handed out past the store size
    a_newctx_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.mop == mcskv_pkg::MOP_NEWCTX) |->
            (r_count < mcskv_pkg::CNT_W'(mcskv_pkg::NUM_ENVS)))
        else $error("new context with store full");
`endif

endmodule

`default_nettype wire
